>>> design/ama_pkg.sv
`timescale 1ns / 1ps

package ama_pkg;

  localparam int ADC_W  = 12;
  localparam int AVG_W  = 20;
  localparam int CFG_W  = 8;
  localparam int FRAC_W = 8;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd100;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_HOLD
  } ama_state_t;

  typedef struct packed {
    logic start;
    logic abort;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> design/ama_store.sv
`timescale 1ns / 1ps

module ama_store import ama_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int IDX_W = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ADC_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ADC_W-1:0] rd_data
);

  logic [ADC_W-1:0] mem [DEPTH];
  logic [ADC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/ama_div.sv
`timescale 1ns / 1ps

module ama_div import ama_pkg::*; #(
  parameter int DW = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctrl_t        ctrl,
  input  logic [DW-1:0]    dividend,
  input  logic [CFG_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DW-1:0]    quotient
);

  localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    quo_r;
  logic [CFG_W-1:0] rem_r;
  logic [CFG_W-1:0] divisor_r;

  logic [CFG_W:0]   rem_sh;
  logic [CFG_W+1:0] diff;
  logic             qbit;
  logic [CFG_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    diff    = {1'b0, rem_sh} - {2'b00, divisor_r};
    qbit    = ~diff[CFG_W+1];
    rem_nxt = qbit ? diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.abort) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

>>> design/adc_moving_average_core.sv
`timescale 1ns / 1ps
// Channel | Ports                                          | Direction
// in      | in_valid, in_stall, in_sample                  | sample item in
// out     | out_valid, out_stall, out_raw_sample, out_average | result item out
// cfg     | cfg_valid, cfg_ready, cfg_window_length        | window length write
//
// One item at a time: accept, a store read, a restoring divider of
// 12 + log2(MAX_WINDOW) + 8 steps (27 at the default), its done flag and a
// load of the output register, which waits while a stalled result holds it;
// the next item is taken only after that load.
// After reset and after every window length write the store is cleared in a
// pass over all MAX_WINDOW addresses during which no item is accepted.
// A stalled result waits in the output register while the next item is taken.

module adc_moving_average_core import ama_pkg::*; #(
  parameter int MAX_WINDOW = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ADC_W-1:0] in_sample,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ADC_W-1:0] out_raw_sample,
  output logic [AVG_W-1:0] out_average,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_window_length
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int SUM_W = ADC_W + IDX_W;
  localparam int DW    = SUM_W + FRAC_W;
  localparam int CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

  ama_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r;
  logic [CFG_W-1:0] window_len_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] wr_addr_r;
  logic [SUM_W-1:0] sum_r;
  logic [ADC_W-1:0] sample_r;
  logic             out_valid_r;
  logic [ADC_W-1:0] out_raw_sample_r;
  logic [AVG_W-1:0] out_average_r;

  logic             cfg_wr;
  logic             in_accept;
  logic             out_free;
  logic [CFG_W-1:0] len;
  logic [IDX_W-1:0] rd_idx;
  logic [CMP_W-1:0] pos_inc;
  logic [IDX_W-1:0] pos_nxt;
  logic [SUM_W-1:0] sum_nxt;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ADC_W-1:0] mem_wr_data;
  logic [ADC_W-1:0] mem_rd_data;

  logic             clearing;
  logic             updating;
  logic             loading;
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DW-1:0]    div_quotient;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (window_len_r == '0) begin
      len = CFG_W'(1);
    end else if (32'(window_len_r) > MAX_WINDOW) begin
      len = CFG_W'(MAX_WINDOW);
    end else begin
      len = window_len_r;
    end
  end

  always_comb begin
    rd_idx  = (CMP_W'(pos_r) >= CMP_W'(len)) ? '0 : pos_r;
    pos_inc = CMP_W'(wr_addr_r) + CMP_W'(1);
    pos_nxt = (pos_inc >= CMP_W'(len)) ? '0 : pos_inc[IDX_W-1:0];
    sum_nxt = sum_r - SUM_W'(mem_rd_data) + SUM_W'(sample_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == IDX_W'(MAX_WINDOW - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    if (cfg_wr) begin
      state_nxt = ST_CLEAR;
    end
  end

  always_comb begin
    clearing = 1'b0;
    updating = 1'b0;
    loading  = 1'b0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR:  clearing = 1'b1;
      ST_IDLE:   in_stall = 1'b0;
      ST_READ:   updating = 1'b1;
      ST_DIVIDE: ;
      ST_HOLD:   loading = out_free;
      default:   ;
    endcase
  end

  assign div_ctrl.start = updating;
  assign div_ctrl.abort = cfg_wr;

  always_comb begin
    mem_wr_en   = clearing || updating;
    mem_wr_addr = clearing ? clr_idx_r : wr_addr_r;
    mem_wr_data = clearing ? '0 : sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      window_len_r <= WINDOW_RESET;
      pos_r        <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        window_len_r <= cfg_window_length;
        clr_idx_r    <= '0;
        pos_r        <= '0;
        sum_r        <= '0;
      end else if (clearing) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end else if (updating) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
      end
      if (loading) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r  <= in_sample;
      wr_addr_r <= rd_idx;
    end
    if (loading) begin
      out_raw_sample_r <= sample_r;
      out_average_r    <= div_quotient[AVG_W-1:0];
    end
  end

  ama_store #(
    .DEPTH (MAX_WINDOW),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_idx),
    .rd_data (mem_rd_data)
  );

  ama_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend ({sum_nxt, {FRAC_W{1'b0}}}),
    .divisor  (len),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  assign out_valid      = out_valid_r;
  assign out_raw_sample = out_raw_sample_r;
  assign out_average    = out_average_r;

`ifndef SYNTH
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> CMP_W'(pos_r) < CMP_W'(len))
    else $error("Write position is outside the window while idle.");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIVIDE)
    else $error("Divider finished outside the divide state.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_free) |=> out_valid_r)
    else $error("Result was not loaded into the output register.");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !cfg_wr) |=> (state_r == ST_READ && !div_stat.busy))
    else $error("Accepted item did not move on to the store read.");
`endif

endmodule

>>> verif/average_checker.sv
`timescale 1ns / 1ps

module average_checker import ama_pkg::*; #(
  parameter int MAX_WINDOW = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ADC_W-1:0] in_sample,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [ADC_W-1:0] out_raw_sample,
  input  logic [AVG_W-1:0] out_average,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_window_length,
  output int               mismatches,
  output int               outstanding,
  output int               results_seen
);

  localparam int SUM_W = ADC_W + $clog2(MAX_WINDOW);

  typedef struct packed {
    logic [ADC_W-1:0] raw_sample;
    logic [AVG_W-1:0] average;
  } avg_result_t;

  logic [ADC_W-1:0] window_store [MAX_WINDOW];
  int unsigned      write_pos;
  logic [SUM_W-1:0] window_sum;
  logic [CFG_W-1:0] window_length;
  avg_result_t      due_results [$];

  // A length of zero acts as one, and anything above the store depth acts as the depth.
  function automatic int unsigned clamped_length(input logic [CFG_W-1:0] len);
    if (len == '0) return 1;
    if (int'(len) > MAX_WINDOW) return MAX_WINDOW;
    return int'(len);
  endfunction

  task automatic clear_window();
    for (int i = 0; i < MAX_WINDOW; i++) window_store[i] = '0;
    write_pos  = 0;
    window_sum = '0;
  endtask

  task automatic take_sample(input logic [ADC_W-1:0] s, output avg_result_t r);
    int unsigned              len;
    logic [SUM_W+FRAC_W-1:0]  scaled;
    len = clamped_length(window_length);
    if (write_pos >= len) write_pos = 0;
    window_sum = window_sum - window_store[write_pos] + s;
    window_store[write_pos] = s;
    write_pos++;
    if (write_pos >= len) write_pos = 0;
    scaled = {window_sum, {FRAC_W{1'b0}}};
    r.raw_sample = s;
    r.average    = AVG_W'(scaled / len);
  endtask

  always @(posedge clk) begin : watch
    avg_result_t got;
    avg_result_t want;
    avg_result_t fresh;
    if (!rst_n) begin
      window_length = WINDOW_RESET;
      clear_window();
      due_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_length = cfg_window_length;
        clear_window();
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        got.raw_sample = out_raw_sample;
        got.average    = out_average;
        if (due_results.size() == 0) begin
          $error("unexpected item: raw_sample %0d average %0d", got.raw_sample, got.average);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.raw_sample !== want.raw_sample) begin
            $error("raw_sample expected %0d actual %0d", want.raw_sample, got.raw_sample);
            mismatches++;
          end
          if (got.average !== want.average) begin
            $error("average expected %0d actual %0d", want.average, got.average);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        take_sample(in_sample, fresh);
        due_results.push_back(fresh);
      end
    end
    outstanding = due_results.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ama_pkg::*;

  localparam int MAX_WINDOW   = 128;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 60;
  localparam int DRAIN_CYCLES = 64;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [ADC_W-1:0] in_sample;
  logic             out_valid;
  logic             out_stall;
  logic [ADC_W-1:0] out_raw_sample;
  logic [AVG_W-1:0] out_average;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_window_length;

  int   mismatches;
  int   outstanding;
  int   results_seen;
  int   cycles      = 0;
  logic quiet       = 1'b0;
  logic hold_active = 1'b0;
  logic hold_done   = 1'b0;

  adc_moving_average_core #(.MAX_WINDOW(MAX_WINDOW)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_raw_sample    (out_raw_sample),
    .out_average       (out_average),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length)
  );

  average_checker #(.MAX_WINDOW(MAX_WINDOW)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_raw_sample    (out_raw_sample),
    .out_average       (out_average),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_seen      (results_seen)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet || hold_active) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [ADC_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return ADC_W'($urandom_range(0, 4095));
  endfunction

  task automatic send_sample(input logic [ADC_W-1:0] s);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The window length is only written once every result has been taken.
  task automatic write_window(input logic [CFG_W-1:0] len);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_window_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  initial begin
    logic [ADC_W-1:0] opening [14];
    logic [CFG_W-1:0] lengths [8];
    int               counts [8];
    logic [CFG_W-1:0] len;
    logic [ADC_W-1:0] s;

    opening = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF,
                12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000,
                12'h001, 12'h800, 12'h7FF, 12'hFFE};
    lengths = '{8'd128, 8'd3, 8'd255, 8'd2, 8'd0, 8'd1, 8'd0, 8'd0};
    counts  = '{140, 30, 50, 30, 15, 15, 85, 85};

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_sample         = '0;
    cfg_valid         = 1'b0;
    cfg_window_length = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) send_sample(opening[i]);

    // Rewriting the reset length still clears the window.
    write_window(WINDOW_RESET);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'h000);

    write_window(8'd0);
    send_sample(12'hFFF);
    send_sample(12'h007);
    send_sample(12'hFFF);

    write_window(8'd255);
    send_sample(12'hFFF);
    send_sample(12'h001);

    for (int p = 0; p < 8; p++) begin
      len = (p >= 6) ? CFG_W'($urandom_range(4, 127)) : lengths[p];
      write_window(len);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < counts[p]; i++) begin
        s = (p == 0 && i < 130) ? '1 : pick_sample();
        send_sample(s);
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/ama_pkg.sv
design/ama_store.sv
design/ama_div.sv
design/adc_moving_average_core.sv
verif/average_checker.sv
verif/tb.sv
